@@ rtl/gbn_pkg.sv @@
// Shared types, constants and slot arithmetic for the Go-Back-N sender window.
package gbn_pkg;

    // Ring geometry
    localparam int WINDOW_DEPTH = 8;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W      = 4;
    localparam int ADD_W        = ((SLOT_W > COUNT_W) ? SLOT_W : COUNT_W) + 1;
    localparam int RESULT_BOUND = 8;
    localparam int LIM_CAP_I    = (WINDOW_DEPTH < RESULT_BOUND) ? WINDOW_DEPTH : RESULT_BOUND;

    typedef logic [SLOT_W-1:0]  slot_idx_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t LIM_CAP = COUNT_W'(LIM_CAP_I);

    // Event codes
    localparam logic [1:0] FUNC_SEND    = 2'd0;
    localparam logic [1:0] FUNC_ACK     = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_SENT    = 3'd0;
    localparam logic [2:0] KIND_REFUSED = 3'd1;
    localparam logic [2:0] KIND_RETX    = 3'd2;
    localparam logic [2:0] KIND_DROPPED = 3'd3;
    localparam logic [2:0] KIND_ACKED   = 3'd4;
    localparam logic [2:0] KIND_EMPTY   = 3'd5;

    // Timer commands
    localparam logic [1:0] TIMER_NONE  = 2'd0;
    localparam logic [1:0] TIMER_START = 2'd1;
    localparam logic [1:0] TIMER_STOP  = 2'd2;

    // Register indexes
    localparam logic REG_RETRY_LIMIT  = 1'b0;
    localparam logic REG_WINDOW_LIMIT = 1'b1;

    localparam logic [3:0] RETRY_LIMIT_RST  = 4'd4;
    localparam logic [3:0] WINDOW_LIMIT_RST = 4'd8;
    localparam logic [3:0] RETRY_MAX        = 4'hF;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] packet_length;
        logic [31:0] ack_number;
    } gbn_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq_out;
        logic [15:0] length_out;
        logic [3:0]  attempt;
        logic [3:0]  outstanding;
        logic [31:0] window_base;
        logic [1:0]  timer_cmd;
        logic        last;
    } gbn_out_t;

    typedef struct packed {
        logic [3:0] retry_limit;
        logic [3:0] window_limit;
    } gbn_cfg_t;

    // One ring slot as stored in memory
    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] length;
        logic [3:0]  retries;
    } gbn_entry_t;

    localparam int ENTRY_W = $bits(gbn_entry_t);

    typedef struct packed {
        logic       we;
        slot_idx_t  waddr;
        gbn_entry_t wdata;
        logic       re;
        slot_idx_t  raddr;
    } gbn_mem_req_t;

    // Ring index plus offset; offset never exceeds the depth
    function automatic slot_idx_t slot_add(slot_idx_t b, count_t o);
        logic [ADD_W-1:0] s;
        s = ADD_W'(b) + ADD_W'(o);
        if (s >= ADD_W'(WINDOW_DEPTH))
        begin
            s = s - ADD_W'(WINDOW_DEPTH);
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

@@ rtl/gbn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/gbn_ctrl.sv @@
// Window sequencer: window pointers, event handling and the timeout walk over the slot RAM.
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  gbn_in_t      req,
    output logic         busy,
    input  gbn_cfg_t     cfg,
    output gbn_mem_req_t mem_req,
    input  gbn_entry_t   mem_rdata,
    output logic         result_valid,
    output gbn_out_t     result
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t      state_reg, state_next;
    slot_idx_t   head_reg, head_next;
    count_t      count_reg, count_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] next_seq_reg, next_seq_next;
    slot_idx_t   walk_base_reg, walk_base_next;
    count_t      idx_reg, idx_next;
    count_t      total_reg, total_next;
    logic        dropping_reg, dropping_next;
    logic        result_valid_reg, result_valid_next;
    gbn_out_t    result_reg, result_next;

    logic        accept;
    count_t      lim;
    logic [31:0] ack_diff;
    count_t      acked;
    count_t      ack_count;
    logic        fin;
    logic [3:0]  retries_inc;

    assign accept = start && (state_reg == S_IDLE);
    assign lim    = (cfg.window_limit > LIM_CAP) ? LIM_CAP : cfg.window_limit;

    // Acknowledgment slide amount, clamped to the outstanding count
    assign ack_diff  = req.ack_number - base_reg;
    assign acked     = (ack_diff > 32'(count_reg)) ? count_reg : ack_diff[COUNT_W-1:0];
    assign ack_count = count_reg - acked;

    // Walk bookkeeping
    assign fin         = (idx_reg + count_t'(1)) == total_reg;
    assign retries_inc = (mem_rdata.retries == RETRY_MAX) ? RETRY_MAX
                                                          : mem_rdata.retries + 4'd1;

    // Next-state logic
    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        base_next         = base_reg;
        next_seq_next     = next_seq_reg;
        walk_base_next    = walk_base_reg;
        idx_next          = idx_reg;
        total_next        = total_reg;
        dropping_next     = dropping_reg;
        result_valid_next = 1'b0;
        result_next       = '0;
        mem_req           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.func)
                        FUNC_SEND:
                        begin
                            result_valid_next       = 1'b1;
                            result_next.last        = 1'b1;
                            result_next.window_base = base_reg;
                            if (count_reg < lim)
                            begin
                                mem_req.we                = 1'b1;
                                mem_req.waddr             = slot_add(head_reg, count_reg);
                                mem_req.wdata.seq         = next_seq_reg;
                                mem_req.wdata.length      = req.packet_length;
                                mem_req.wdata.retries     = '0;
                                count_next                = count_reg + count_t'(1);
                                next_seq_next             = next_seq_reg + 32'd1;
                                result_next.kind          = KIND_SENT;
                                result_next.seq_out       = next_seq_reg;
                                result_next.length_out    = req.packet_length;
                                result_next.outstanding   = count_reg + count_t'(1);
                                result_next.timer_cmd     = (count_reg == '0) ? TIMER_START
                                                                              : TIMER_NONE;
                            end
                            else
                            begin
                                result_next.kind        = KIND_REFUSED;
                                result_next.outstanding = count_reg;
                            end
                        end
                        FUNC_ACK:
                        begin
                            result_valid_next = 1'b1;
                            result_next.kind  = KIND_ACKED;
                            result_next.last  = 1'b1;
                            if (req.ack_number > base_reg)
                            begin
                                head_next               = slot_add(head_reg, acked);
                                count_next              = ack_count;
                                base_next               = req.ack_number;
                                result_next.outstanding = ack_count;
                                result_next.window_base = req.ack_number;
                                result_next.timer_cmd   = (ack_count != '0) ? TIMER_START
                                                                            : TIMER_STOP;
                            end
                            else
                            begin
                                result_next.outstanding = count_reg;
                                result_next.window_base = base_reg;
                                result_next.timer_cmd   = (count_reg != '0) ? TIMER_START
                                                                            : TIMER_STOP;
                            end
                        end
                        FUNC_TIMEOUT:
                        begin
                            if (count_reg == '0)
                            begin
                                result_valid_next       = 1'b1;
                                result_next.kind        = KIND_EMPTY;
                                result_next.last        = 1'b1;
                                result_next.window_base = base_reg;
                            end
                            else
                            begin
                                // prefetch the head slot, then walk the window
                                mem_req.re     = 1'b1;
                                mem_req.raddr  = head_reg;
                                walk_base_next = head_reg;
                                idx_next       = '0;
                                total_next     = count_reg;
                                dropping_next  = 1'b1;
                                state_next     = S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // read the following slot while this one is handled
                mem_req.re             = 1'b1;
                mem_req.raddr          = slot_add(walk_base_reg, idx_reg + count_t'(1));
                result_valid_next      = 1'b1;
                result_next.seq_out    = mem_rdata.seq;
                result_next.length_out = mem_rdata.length;
                result_next.last       = fin;
                if (dropping_reg && (mem_rdata.retries >= cfg.retry_limit))
                begin
                    head_next               = slot_add(head_reg, count_t'(1));
                    count_next              = count_reg - count_t'(1);
                    base_next               = base_reg + 32'd1;
                    result_next.kind        = KIND_DROPPED;
                    result_next.attempt     = mem_rdata.retries;
                    result_next.outstanding = count_reg - count_t'(1);
                    result_next.window_base = base_reg + 32'd1;
                    result_next.timer_cmd   = TIMER_NONE;
                end
                else
                begin
                    dropping_next           = 1'b0;
                    mem_req.we              = 1'b1;
                    mem_req.waddr           = slot_add(walk_base_reg, idx_reg);
                    mem_req.wdata.seq       = mem_rdata.seq;
                    mem_req.wdata.length    = mem_rdata.length;
                    mem_req.wdata.retries   = retries_inc;
                    result_next.kind        = KIND_RETX;
                    result_next.attempt     = retries_inc;
                    result_next.outstanding = count_reg;
                    result_next.window_base = base_reg;
                    result_next.timer_cmd   = fin ? TIMER_START : TIMER_NONE;
                end
                idx_next = idx_reg + count_t'(1);
                if (fin)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            count_reg        <= '0;
            base_reg         <= '0;
            next_seq_reg     <= '0;
            walk_base_reg    <= '0;
            idx_reg          <= '0;
            total_reg        <= '0;
            dropping_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            base_reg         <= base_next;
            next_seq_reg     <= next_seq_next;
            walk_base_reg    <= walk_base_next;
            idx_reg          <= idx_next;
            total_reg        <= total_next;
            dropping_reg     <= dropping_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/go_back_n_sender_window.sv @@
// Top level of the Go-Back-N sender window: configuration registers, slot RAM and sequencer.
//
// For send, acknowledgment and empty-window timeout events the item is taken
// when start is high and busy is low, and its single result appears with result_valid
// in the next cycle. A timeout over n outstanding entries keeps busy high while the
// sequencer walks them and delivers n results on consecutive cycles (drops first, then
// retransmits, last marked); no new item is taken until the walk ends. The slot RAM's
// one read port visits one entry per cycle. Results are shown for exactly one cycle each
// and the receiver cannot stall them. Configuration writes are always ready and should be
// issued only while the block is idle.
module go_back_n_sender_window
    import gbn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  gbn_in_t  req,
    output logic     busy,
    output logic     result_valid,
    output gbn_out_t result,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_index,
    input  logic [3:0] cfg_data
);

    gbn_cfg_t     cfg_reg;
    gbn_mem_req_t mem_req;
    gbn_entry_t   mem_rdata;
    logic [ENTRY_W-1:0] rdata_raw;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit  <= RETRY_LIMIT_RST;
            cfg_reg.window_limit <= WINDOW_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_RETRY_LIMIT)
            begin
                cfg_reg.retry_limit <= cfg_data;
            end
            else
            begin
                cfg_reg.window_limit <= cfg_data;
            end
        end
    end

    assign cfg_ready = 1'b1;

    // Slot storage: sequence number, length and retry count per ring slot
    gbn_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_slot_ram (
        .clk  (clk),
        .we   (mem_req.we),
        .waddr(mem_req.waddr),
        .wdata(mem_req.wdata),
        .re   (mem_req.re),
        .raddr(mem_req.raddr),
        .rdata(rdata_raw)
    );

    assign mem_rdata = rdata_raw;

    // Event sequencer
    gbn_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req),
        .busy        (busy),
        .cfg         (cfg_reg),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the Go-Back-N sender window: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top
    import gbn_pkg::*;
();

    localparam int CLK_PERIOD  = 10;
    localparam int STALL_LIMIT = 2000;

    // func code that the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        gbn_in_t  ev;
        logic     typed;
        gbn_out_t want;
    } dir_row_t;

    // DUT signals; the driven inputs are all known from time zero
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    gbn_in_t    req = '0;
    logic       busy;
    logic       result_valid;
    gbn_out_t   result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = REG_RETRY_LIMIT;
    logic [3:0] cfg_data = 4'd0;

    // Window model state
    logic [31:0] ring_seq   [WINDOW_DEPTH];
    logic [15:0] ring_len   [WINDOW_DEPTH];
    logic [3:0]  ring_tries [WINDOW_DEPTH];
    int          ring_head = 0;
    int          ring_count = 0;
    logic [31:0] win_base = 32'd0;
    logic [31:0] seq_to_send = 32'd0;
    logic [3:0]  retry_lim = RETRY_LIMIT_RST;
    logic [3:0]  win_lim = WINDOW_LIMIT_RST;

    gbn_out_t window_results [$];
    gbn_out_t due_results [$];
    dir_row_t dir_rows [$];

    int errors = 0;
    int events_done = 0;
    int settings_run = 0;
    int results_seen = 0;
    int sent_seen = 0;
    int refused_seen = 0;
    int retx_seen = 0;
    int dropped_seen = 0;
    int quiet_cycles = 0;

    go_back_n_sender_window i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic gbn_out_t mk_out(input logic [2:0] kind, input logic [31:0] seq,
                                        input logic [15:0] len, input logic [3:0] att,
                                        input logic [3:0] outst, input logic [31:0] base,
                                        input logic [1:0] tcmd, input logic fin);
        gbn_out_t r;
        r.kind        = kind;
        r.seq_out     = seq;
        r.length_out  = len;
        r.attempt     = att;
        r.outstanding = outst;
        r.window_base = base;
        r.timer_cmd   = tcmd;
        r.last        = fin;
        return r;
    endfunction

    // Apply one event to the window model; its results land in window_results
    function automatic void advance_window(gbn_in_t ev);
        int          cap;
        int          slot;
        int          total;
        int          n_out;
        logic [31:0] slide;
        logic        fin;
        window_results.delete();
        case (ev.func)
            FUNC_SEND:
            begin
                cap = int'(win_lim);
                if (cap > LIM_CAP_I)
                begin
                    cap = LIM_CAP_I;
                end
                if (ring_count < cap)
                begin
                    slot = (ring_head + ring_count) % WINDOW_DEPTH;
                    ring_seq[slot]   = seq_to_send;
                    ring_len[slot]   = ev.packet_length;
                    ring_tries[slot] = 4'd0;
                    ring_count++;
                    window_results.push_back(mk_out(KIND_SENT, seq_to_send, ev.packet_length,
                        4'd0, 4'(ring_count), win_base,
                        (ring_count == 1) ? TIMER_START : TIMER_NONE, 1'b1));
                    seq_to_send = seq_to_send + 32'd1;
                end
                else
                begin
                    window_results.push_back(mk_out(KIND_REFUSED, 32'd0, 16'd0, 4'd0,
                        4'(ring_count), win_base, TIMER_NONE, 1'b1));
                end
            end
            FUNC_ACK:
            begin
                if (ev.ack_number > win_base)
                begin
                    slide = ev.ack_number - win_base;
                    if (slide > 32'(ring_count))
                    begin
                        slide = 32'(ring_count);
                    end
                    ring_head  = (ring_head + int'(slide)) % WINDOW_DEPTH;
                    ring_count = ring_count - int'(slide);
                    win_base   = ev.ack_number;
                end
                window_results.push_back(mk_out(KIND_ACKED, 32'd0, 16'd0, 4'd0,
                    4'(ring_count), win_base, (ring_count > 0) ? TIMER_START : TIMER_STOP,
                    1'b1));
            end
            FUNC_TIMEOUT:
            begin
                if (ring_count == 0)
                begin
                    window_results.push_back(mk_out(KIND_EMPTY, 32'd0, 16'd0, 4'd0, 4'd0,
                        win_base, TIMER_NONE, 1'b1));
                end
                else
                begin
                    total = ring_count;
                    n_out = 0;
                    // head entries at the retry limit go first
                    while (ring_count > 0 && ring_tries[ring_head] >= retry_lim)
                    begin
                        slot       = ring_head;
                        ring_head  = (ring_head + 1) % WINDOW_DEPTH;
                        ring_count--;
                        win_base   = win_base + 32'd1;
                        window_results.push_back(mk_out(KIND_DROPPED, ring_seq[slot],
                            ring_len[slot], ring_tries[slot], 4'(ring_count), win_base,
                            TIMER_NONE, (n_out + 1 == total)));
                        n_out++;
                    end
                    // everything left is sent again
                    for (int i = 0; i < ring_count; i++)
                    begin
                        slot = (ring_head + i) % WINDOW_DEPTH;
                        if (ring_tries[slot] != RETRY_MAX)
                        begin
                            ring_tries[slot] = ring_tries[slot] + 4'd1;
                        end
                        fin = (i + 1 == ring_count);
                        window_results.push_back(mk_out(KIND_RETX, ring_seq[slot],
                            ring_len[slot], ring_tries[slot], 4'(ring_count), win_base,
                            fin ? TIMER_START : TIMER_NONE, fin));
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void add_row(input logic [1:0] f, input logic [15:0] len,
                                    input logic [31:0] ack, input logic typed,
                                    input gbn_out_t want);
        dir_row_t r;
        r.ev.func          = f;
        r.ev.packet_length = len;
        r.ev.ack_number    = ack;
        r.typed            = typed;
        r.want             = want;
        dir_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic report_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    // Present one item at a falling edge, hold it until taken, then predict
    task automatic drive_event(input gbn_in_t ev, input int idle_pct, input logic typed,
                               input gbn_out_t want);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            do
            begin
                @(negedge clk);
            end
            while ($urandom_range(99) < idle_pct);
        end
        start = 1'b1;
        req   = ev;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        advance_window(ev);
        if (typed)
        begin
            due_results.push_back(want);
        end
        else
        begin
            foreach (window_results[i])
            begin
                due_results.push_back(window_results[i]);
            end
        end
        if (ev.func != FUNC_UNUSED)
        begin
            events_done++;
        end
        @(negedge clk);
    endtask

    // Hold off until every expected result is in, plus a timeout's worth of cycles
    task automatic wait_idle();
        while (due_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (WINDOW_DEPTH + 2) @(negedge clk);
    endtask

    // New limits, then a stretch of random traffic under them
    task automatic run_phase(input logic [3:0] rl, input logic [3:0] wl, input int idle_pct,
                             input int n_events);
        gbn_in_t     ev;
        int          pick;
        int          sub;
        int          taken;
        logic [31:0] back;
        start = 1'b0;
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = REG_RETRY_LIMIT;
        cfg_data  = rl;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        retry_lim = rl;
        @(negedge clk);
        cfg_index = REG_WINDOW_LIMIT;
        cfg_data  = wl;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        win_lim = wl;
        @(negedge clk);
        cfg_valid = 1'b0;
        settings_run++;

        taken = 0;
        while (taken < n_events)
        begin
            ev.packet_length = 16'($urandom);
            ev.ack_number    = $urandom;
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                ev.func = FUNC_SEND;
            end
            else if (pick < 75)
            begin
                ev.func = FUNC_ACK;
                sub = $urandom_range(99);
                if (sub < 60 && ring_count > 0)
                begin
                    // normal cumulative ack inside the window
                    ev.ack_number = win_base + 32'($urandom_range(ring_count, 1));
                end
                else if (sub < 75)
                begin
                    // duplicate or stale ack
                    back = 32'($urandom_range(2));
                    if (back > win_base)
                    begin
                        back = win_base;
                    end
                    ev.ack_number = win_base - back;
                end
                else if (sub < 90)
                begin
                    // ack past everything sent
                    ev.ack_number = win_base + 32'(ring_count) + 32'($urandom_range(4, 1));
                end
            end
            else if (pick < 95)
            begin
                ev.func = FUNC_TIMEOUT;
            end
            else
            begin
                ev.func = FUNC_UNUSED;
            end
            // occasional full drain before the next item
            if ($urandom_range(99) < 3)
            begin
                start = 1'b0;
                wait_idle();
            end
            drive_event(ev, idle_pct, 1'b0, '0);
            if (ev.func != FUNC_UNUSED)
            begin
                taken++;
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        gbn_out_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            case (result.kind)
                KIND_SENT:    sent_seen++;
                KIND_REFUSED: refused_seen++;
                KIND_RETX:    retx_seen++;
                KIND_DROPPED: dropped_seen++;
                default:
                begin
                end
            endcase
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result, kind %0d seq %0h",
                    result.kind, result.seq_out));
            end
            else
            begin
                want = due_results.pop_front();
                report_field("kind", 32'(result.kind), 32'(want.kind));
                report_field("seq_out", result.seq_out, want.seq_out);
                report_field("length_out", 32'(result.length_out), 32'(want.length_out));
                report_field("attempt", 32'(result.attempt), 32'(want.attempt));
                report_field("outstanding", 32'(result.outstanding), 32'(want.outstanding));
                report_field("window_base", result.window_base, want.window_base);
                report_field("timer_cmd", 32'(result.timer_cmd), 32'(want.timer_cmd));
                report_field("last", 32'(result.last), 32'(want.last));
            end
        end
    end

    // Watchdog: any handshake counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
                    STALL_LIMIT, due_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed rows, run at the reset limits (retry 4, window 8)
        add_row(FUNC_TIMEOUT, 16'h0000, 32'h0000_0000, 1'b1,
            mk_out(KIND_EMPTY, 32'd0, 16'd0, 4'd0, 4'd0, 32'd0, TIMER_NONE, 1'b1));
        add_row(FUNC_ACK, 16'hFFFF, 32'h0000_0000, 1'b1,
            mk_out(KIND_ACKED, 32'd0, 16'd0, 4'd0, 4'd0, 32'd0, TIMER_STOP, 1'b1));
        add_row(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(FUNC_SEND, 16'h0000, 32'hFFFF_FFFF, 1'b1,
            mk_out(KIND_SENT, 32'd0, 16'h0000, 4'd0, 4'd1, 32'd0, TIMER_START, 1'b1));
        add_row(FUNC_SEND, 16'hFFFF, 32'h0000_0000, 1'b1,
            mk_out(KIND_SENT, 32'd1, 16'hFFFF, 4'd0, 4'd2, 32'd0, TIMER_NONE, 1'b1));
        add_row(FUNC_SEND, 16'h5555, 32'hAAAA_AAAA, 1'b0, '0);
        add_row(FUNC_SEND, 16'hAAAA, 32'h5555_5555, 1'b0, '0);
        add_row(FUNC_SEND, 16'h1234, 32'h0000_0000, 1'b0, '0);
        add_row(FUNC_SEND, 16'h8000, 32'h0000_0000, 1'b0, '0);
        add_row(FUNC_SEND, 16'h0001, 32'h0000_0000, 1'b0, '0);
        add_row(FUNC_SEND, 16'h7FFF, 32'h0000_0000, 1'b0, '0);
        // window full
        add_row(FUNC_SEND, 16'h4321, 32'h0000_0000, 1'b1,
            mk_out(KIND_REFUSED, 32'd0, 16'd0, 4'd0, 4'd8, 32'd0, TIMER_NONE, 1'b1));
        add_row(FUNC_TIMEOUT, 16'h0000, 32'h0000_0000, 1'b0, '0);
        add_row(FUNC_ACK, 16'h0000, 32'd3, 1'b0, '0);
        // stale and duplicate acks
        add_row(FUNC_ACK, 16'h0000, 32'd2, 1'b0, '0);
        add_row(FUNC_ACK, 16'h0000, 32'd3, 1'b0, '0);
        // three retransmit rounds, then the fourth drops the whole window
        add_row(FUNC_TIMEOUT, 16'h0000, 32'h0000_0000, 1'b0, '0);
        add_row(FUNC_TIMEOUT, 16'h0000, 32'h0000_0000, 1'b0, '0);
        add_row(FUNC_TIMEOUT, 16'h0000, 32'h0000_0000, 1'b0, '0);
        add_row(FUNC_TIMEOUT, 16'h0000, 32'h0000_0000, 1'b0, '0);
        // acks beyond what is outstanding
        add_row(FUNC_ACK, 16'h0000, 32'd100, 1'b0, '0);
        add_row(FUNC_SEND, 16'hBEEF, 32'h0000_0000, 1'b0, '0);
        add_row(FUNC_ACK, 16'h0000, 32'd250, 1'b0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            drive_event(dir_rows[i].ev, 0, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random traffic under a spread of limits and idle rates
        run_phase(4'd3, 4'd8, 0, 90);
        run_phase(4'd1, 4'd4, 66, 80);
        run_phase(4'd15, 4'd15, 14, 90);
        run_phase(4'd0, 4'd1, 0, 60);
        run_phase(4'd2, 4'd0, 66, 30);
        run_phase(4'd6, 4'd8, 14, 100);

        start = 1'b0;
        wait_idle();

        $display("Covered %0d events over %0d limit settings plus the reset limits.",
            events_done, settings_run);
        $display("Checked %0d results: %0d sent, %0d refused, %0d retransmitted, %0d dropped.",
            results_seen, sent_seen, refused_seen, retx_seen, dropped_seen);
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
